### design/stepper_step_dir_generator_assert.svh
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_assert.svh
// assertion macros shared by the step/dir generator modules
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_DIR_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_DIR_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdg assertion failed");

// next-cycle implication, checked out of reset
`define SDG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdg assertion failed");

`endif

### design/sdg_pkg.sv
// ----------------------------------------------------------------------------
// sdg_pkg
// widths and word types of the step/dir generator
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int POSITION_BITS    = 32;
  localparam int PHASE_COUNT_BITS = 16;
  localparam int HALF_PERIOD_BITS = 16;
  localparam int TARGET_BITS      = 32;
  localparam int OUT_POS_BITS     = 32;
  localparam int CMP_BITS = (PHASE_COUNT_BITS > HALF_PERIOD_BITS) ?
                            PHASE_COUNT_BITS : HALF_PERIOD_BITS;

  localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = HALF_PERIOD_BITS'(100);

  typedef logic [POSITION_BITS-1:0]    pos_t;
  typedef logic [PHASE_COUNT_BITS-1:0] phase_t;
  typedef logic [HALF_PERIOD_BITS-1:0] half_t;

  typedef struct packed {
    logic                          load_target;
    logic signed [TARGET_BITS-1:0] new_target;
  } sdg_item_t;

  typedef struct packed {
    logic                           step_level;
    logic                           dir_level;
    logic                           moving;
    logic signed [OUT_POS_BITS-1:0] current_position;
  } sdg_result_t;

endpackage

### design/sdg_core.sv
// ----------------------------------------------------------------------------
// sdg_core
// motion state and single-tick update; commits when advance is high
// ----------------------------------------------------------------------------
module sdg_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  sdg_pkg::sdg_item_t  item,
  input  sdg_pkg::half_t      half_period,
  output sdg_pkg::sdg_result_t result
);
  import sdg_pkg::*;
  `include "stepper_step_dir_generator_assert.svh"

  pos_t   pos_r, pos_nxt;
  pos_t   tgt_r, tgt_nxt;
  logic   drv_r, drv_nxt;
  logic   reeval_r, reeval_nxt;
  phase_t phase_r, phase_nxt;
  logic   high_r, high_nxt;
  logic   up_r, up_nxt;
  logic   step_r, step_nxt;
  logic   dir_r, dir_nxt;
  phase_t phase_inc;

  always_comb begin
    tgt_nxt    = item.load_target ? POSITION_BITS'(item.new_target) : tgt_r;
    pos_nxt    = pos_r;
    drv_nxt    = drv_r;
    reeval_nxt = reeval_r;
    phase_nxt  = phase_r;
    high_nxt   = high_r;
    up_nxt     = up_r;
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    phase_inc  = '0;

    // compare target with position when idle or right after a step
    if (reeval_r || !drv_r) begin
      reeval_nxt = 1'b0;
      if (tgt_nxt == pos_r) begin
        drv_nxt = 1'b0;
      end else begin
        phase_nxt = '0;
        high_nxt  = 1'b1;
        up_nxt    = $signed(tgt_nxt) > $signed(pos_r);
        drv_nxt   = 1'b1;
      end
    end

    if (drv_nxt) begin
      step_nxt  = high_nxt;
      dir_nxt   = up_nxt;
      phase_inc = phase_nxt + 1'b1;
      phase_nxt = phase_inc;
      if (CMP_BITS'(phase_inc) >= CMP_BITS'(half_period)) begin
        if (high_nxt) begin
          high_nxt  = 1'b0;
          phase_nxt = '0;
        end else begin
          pos_nxt    = up_nxt ? pos_r + 1'b1 : pos_r - 1'b1;
          reeval_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tgt_r    <= '0;
      drv_r    <= 1'b0;
      reeval_r <= 1'b0;
      phase_r  <= '0;
      high_r   <= 1'b1;
      up_r     <= 1'b0;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      tgt_r    <= tgt_nxt;
      drv_r    <= drv_nxt;
      reeval_r <= reeval_nxt;
      phase_r  <= phase_nxt;
      high_r   <= high_nxt;
      up_r     <= up_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
    end
  end

  assign result.step_level       = step_nxt;
  assign result.dir_level        = dir_nxt;
  assign result.moving           = drv_nxt;
  assign result.current_position = OUT_POS_BITS'(pos_nxt);

  `SDG_ASSERT_IMP(a_reeval_only_driving, reeval_r, drv_r)
  `SDG_ASSERT_NXT(a_pos_one_step, advance,
    (pos_r == $past(pos_r)) || (pos_r == $past(pos_r) + 1'b1) ||
    (pos_r == $past(pos_r) - 1'b1))
  `SDG_ASSERT_NXT(a_pos_moves_on_low, advance && (pos_nxt != pos_r), reeval_r && !high_r)

endmodule

### design/stepper_step_dir_generator.sv
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// step/direction pulse generator for one stepper motor, one word per tick
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// cfg      in   cfg_wr_en             cfg_wr_data (half_period)
// in       in   in_valid / in_ready   in_load_target, in_new_target
// out      out  out_valid / out_ready out_step_level, out_dir_level,
//                                     out_moving, out_current_position
//
// one word per cycle sustained while out_ready holds high; a word waits in the input register,
// the state update runs as it moves to the output register
// out_valid rises once the word has passed the input and output registers, when the output is free
// reset (rst_n low, synchronous) empties both registers, position and target 0,
// idle, half_period 100
// a stall on out holds the result; in_ready stays high while the input
// register is empty or moving forward
// ----------------------------------------------------------------------------
module stepper_step_dir_generator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [sdg_pkg::HALF_PERIOD_BITS-1:0]    cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_load_target,
  input  logic signed [sdg_pkg::TARGET_BITS-1:0]  in_new_target,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_step_level,
  output logic                                    out_dir_level,
  output logic                                    out_moving,
  output logic signed [sdg_pkg::OUT_POS_BITS-1:0] out_current_position
);
  import sdg_pkg::*;
  `include "stepper_step_dir_generator_assert.svh"

  half_t       half_r;
  logic        in_vld_r;
  sdg_item_t   in_word_r;
  logic        out_vld_r;
  sdg_result_t out_word_r;
  sdg_result_t core_res;
  logic        advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r.load_target <= in_load_target;
      in_word_r.new_target  <= in_new_target;
    end
    if (advance) begin
      out_word_r <= core_res;
    end
  end

  sdg_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (in_word_r),
    .half_period (half_r),
    .result      (core_res)
  );

  assign out_valid            = out_vld_r;
  assign out_step_level       = out_word_r.step_level;
  assign out_dir_level        = out_word_r.dir_level;
  assign out_moving           = out_word_r.moving;
  assign out_current_position = out_word_r.current_position;

  `SDG_ASSERT_NXT(a_advance_fills_out, advance, out_vld_r)
  `SDG_ASSERT_IMP(a_ready_when_out_free, !out_vld_r, in_ready)

endmodule

### verif/sdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdg_checker
// Follows every word into and out of the step/dir generator. Each accepted
// input tick advances a private copy of the motor state and queues the levels
// and position that tick must produce. Each accepted output word is compared
// field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module sdg_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  sdg_pkg::half_t                          cfg_wr_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic                                    in_load_target,
  input  logic signed [sdg_pkg::TARGET_BITS-1:0]  in_new_target,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic                                    out_step_level,
  input  logic                                    out_dir_level,
  input  logic                                    out_moving,
  input  logic signed [sdg_pkg::OUT_POS_BITS-1:0] out_current_position,
  output int                                      errors,
  output int                                      pending,
  output int                                      checked,
  output sdg_pkg::pos_t                           position_now
);
  import sdg_pkg::*;

  half_t  half_period;
  pos_t   position;
  pos_t   target;
  logic   driving;
  logic   reeval;
  phase_t phase;
  logic   phase_high;
  logic   heading_up;
  logic   step_q;
  logic   dir_q;

  sdg_result_t predicted_ticks[$];
  int          mismatch_count = 0;
  int          match_count = 0;

  // one timer tick of the motor: optional target load, compare, pulse timing
  function automatic sdg_result_t advance_motor(input logic load,
                                                input logic [TARGET_BITS-1:0] tgt);
    sdg_result_t levels;
    if (load) begin
      target = pos_t'($signed(tgt));
    end
    if (reeval || !driving) begin
      reeval = 1'b0;
      if (target == position) begin
        driving = 1'b0;
      end else begin
        phase      = '0;
        phase_high = 1'b1;
        heading_up = $signed(target) > $signed(position);
        driving    = 1'b1;
      end
    end
    if (driving) begin
      step_q = phase_high;
      dir_q  = heading_up;
      phase  = phase + 1'b1;
      if (phase >= half_period) begin
        if (phase_high) begin
          phase_high = 1'b0;
          phase      = '0;
        end else begin
          position = heading_up ? position + 1'b1 : position - 1'b1;
          reeval   = 1'b1;
        end
      end
    end
    levels.step_level       = step_q;
    levels.dir_level        = dir_q;
    levels.moving           = driving;
    levels.current_position = position[OUT_POS_BITS-1:0];
    return levels;
  endfunction

  always @(posedge clk) begin
    sdg_result_t want;
    sdg_result_t got;
    if (!rst_n) begin
      half_period = HALF_PERIOD_RESET;
      position    = '0;
      target      = '0;
      driving     = 1'b0;
      reeval      = 1'b0;
      phase       = '0;
      phase_high  = 1'b1;
      heading_up  = 1'b0;
      step_q      = 1'b0;
      dir_q       = 1'b0;
      predicted_ticks.delete();
    end else begin
      if (cfg_wr_en) begin
        half_period = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        predicted_ticks.push_back(advance_motor(in_load_target, in_new_target));
      end
      if (out_valid && out_ready) begin
        got.step_level       = out_step_level;
        got.dir_level        = out_dir_level;
        got.moving           = out_moving;
        got.current_position = out_current_position;
        if (predicted_ticks.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%t sdg_checker: unexpected word: step %b dir %b moving %b pos %0d",
                     $realtime, got.step_level, got.dir_level, got.moving,
                     got.current_position);
          end
          mismatch_count++;
        end else begin
          want = predicted_ticks.pop_front();
          if (got.step_level !== want.step_level || got.dir_level !== want.dir_level ||
              got.moving !== want.moving ||
              got.current_position !== want.current_position) begin
            if (mismatch_count < 10) begin
              $display("%t sdg_checker: expected step %b dir %b moving %b pos %0d",
                       $realtime, want.step_level, want.dir_level, want.moving,
                       want.current_position);
              $display("%t sdg_checker:      got step %b dir %b moving %b pos %0d",
                       $realtime, got.step_level, got.dir_level, got.moving,
                       got.current_position);
            end
            mismatch_count++;
          end else begin
            match_count++;
          end
        end
      end
    end
    errors       <= mismatch_count;
    pending      <= predicted_ticks.size();
    checked      <= match_count;
    position_now <= position;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives timer ticks into the step/dir generator with random gaps on both
// channels, walks half_period through its extremes and a few ordinary values,
// and leaves prediction and comparison to sdg_checker.
// ----------------------------------------------------------------------------
module tb;
  import sdg_pkg::*;

  localparam int PHASE_WORDS = 220;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  half_t                          cfg_wr_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_load_target = 1'b0;
  logic signed [TARGET_BITS-1:0]  in_new_target = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_step_level;
  logic                           out_dir_level;
  logic                           out_moving;
  logic signed [OUT_POS_BITS-1:0] out_current_position;

  int   errors;
  int   pending;
  int   checked;
  pos_t position_now;

  int sent = 0;
  int n_settings = 0;
  int tx_style = 0;
  int rx_style = 0;

  always #5 clk = ~clk;

  stepper_step_dir_generator u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_load_target       (in_load_target),
    .in_new_target        (in_new_target),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_step_level       (out_step_level),
    .out_dir_level        (out_dir_level),
    .out_moving           (out_moving),
    .out_current_position (out_current_position)
  );

  sdg_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_load_target       (in_load_target),
    .in_new_target        (in_new_target),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_step_level       (out_step_level),
    .out_dir_level        (out_dir_level),
    .out_moving           (out_moving),
    .out_current_position (out_current_position),
    .errors               (errors),
    .pending              (pending),
    .checked              (checked),
    .position_now         (position_now)
  );

  // 0: back to back, 1: full spread, 2: mostly back to back with odd long gaps
  function automatic int draw_gap(input int style);
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  task automatic send_word(input logic load, input logic [TARGET_BITS-1:0] tgt);
    int gap;
    if (sent % 40 == 0) begin
      tx_style = $urandom_range(0, 2);
    end
    gap = draw_gap(tx_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_load_target <= load;
    in_new_target  <= tgt;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // hold the input off until every predicted word has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_half(input half_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  // mostly targets a few steps from the current position so moves finish
  // and the block goes idle; some far and extreme targets mixed in
  task automatic random_phase(input int count);
    int pick;
    int off;
    logic load;
    logic [TARGET_BITS-1:0] tgt;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      off  = $urandom_range(0, 12) - 6;
      load = (pick < 18);
      if (pick < 12) begin
        tgt = position_now + off;
      end else if (pick < 15) begin
        tgt = $urandom;
      end else if (pick < 17) begin
        case ($urandom_range(0, 3))
          0:       tgt = 32'h7fff_ffff;
          1:       tgt = 32'h8000_0000;
          2:       tgt = '0;
          default: tgt = '1;
        endcase
      end else if (pick < 18) begin
        tgt = position_now;
      end else begin
        tgt = $urandom;
      end
      send_word(load, tgt);
    end
  endtask

  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken % 40 == 0) begin
        rx_style = $urandom_range(0, 2);
      end
      stall = draw_gap(rx_style);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    half_t plan [7];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: idle at zero, then a short move that cannot finish yet
    send_word(1'b0, '0);
    send_word(1'b1, 32'd0);
    send_word(1'b1, 32'd2);
    send_word(1'b0, '1);
    random_phase(PHASE_WORDS);

    drain();
    write_half(16'd1);
    // target equal to position, short move, reversal mid-pulse, field extremes
    send_word(1'b1, 32'd0);
    send_word(1'b0, 32'hffff_ffff);
    send_word(1'b1, 32'd3);
    send_word(1'b0, '0);
    send_word(1'b0, '0);
    send_word(1'b1, -32'sd2);
    repeat (6) send_word(1'b0, '0);
    send_word(1'b1, 32'h7fff_ffff);
    send_word(1'b0, '0);
    send_word(1'b0, '0);
    send_word(1'b1, 32'h8000_0000);
    send_word(1'b0, '0);
    send_word(1'b0, '0);
    send_word(1'b1, 32'hffff_ffff);
    repeat (5) send_word(1'b0, '0);
    random_phase(PHASE_WORDS);

    plan = '{16'd0, 16'd2, 16'hffff, 16'd3, half_t'($urandom_range(4, 9)),
             half_t'($urandom_range(1, 65535)), 16'd1};
    foreach (plan[k]) begin
      drain();
      write_half(plan[k]);
      random_phase(PHASE_WORDS);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("tb: %0d ticks driven across %0d half_period settings (0, 1, 65535 included)",
             sent, n_settings + 1);
    $display("tb: %0d output words matched, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/sdg_pkg.sv
design/sdg_core.sv
design/stepper_step_dir_generator.sv
verif/sdg_checker.sv
verif/tb.sv
